@@ sv/sut_pkg.sv @@
package sut_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int KEY_W     = 32;
	localparam int OP_W      = 2;
	localparam int POS_W     = 5;
	localparam int CNT_W     = 5;

	typedef enum logic [OP_W-1:0] {
		OP_INSERT  = 2'd0,
		OP_REMOVE  = 2'd1,
		OP_REPLACE = 2'd2,
		OP_SEARCH  = 2'd3
	} sut_op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_PLAN,
		ST_SHIFT,
		ST_PUT,
		ST_DONE
	} sut_state_t;

	typedef struct packed {
		logic accept;
		logic scan;
		logic plan;
		logic shift;
		logic put;
		logic out_load;
	} sut_cmd_t;

	typedef struct packed {
		logic scan_done;
		logic shift_done;
		logic out_free;
	} sut_sts_t;

endpackage

@@ sv/sut_ram.sv @@
module sut_ram #(
	parameter int W = 32,
	parameter int D = 16,
	localparam int AW = (D > 1) ? $clog2(D) : 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);

	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ sv/sut_datapath.sv @@
module sut_datapath #(
	parameter int DEPTH = sut_pkg::DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  sut_pkg::sut_cmd_t                 cmd,
	output sut_pkg::sut_sts_t                 sts,
	input  logic [sut_pkg::OP_W-1:0]          opcode,
	input  logic signed [sut_pkg::KEY_W-1:0]  key,
	input  logic signed [sut_pkg::KEY_W-1:0]  new_key,
	input  logic                              out_stall,
	output logic                              out_valid,
	output logic                              ok,
	output logic signed [sut_pkg::POS_W-1:0]  position,
	output logic [sut_pkg::CNT_W-1:0]         entry_count
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int KW = sut_pkg::KEY_W;
	localparam int PW = sut_pkg::POS_W;
	localparam int NW = sut_pkg::CNT_W;

	// request and scan results
	sut_pkg::sut_op_t  op_q;
	logic signed [KW-1:0] key_q;
	logic signed [KW-1:0] nkey_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] idx_q;
	logic          pend_q;
	logic          found_k_q;
	logic          found_nk_q;
	logic [CW-1:0] pk_q;
	logic [CW-1:0] ltk_q;
	logic [CW-1:0] ltnk_q;

	// move plan
	logic          okp_q;
	logic          up_q;
	logic          put_q;
	logic [AW-1:0] paddr_q;
	logic [AW-1:0] src_q;
	logic [AW-1:0] last_q;
	logic [CW-1:0] rem_q;

	// result word
	logic          out_valid_q;
	logic          ok_q;
	logic [PW-1:0] pos_q;
	logic [NW-1:0] ocnt_q;

	logic [KW-1:0] rd_data;
	logic          we;
	logic [AW-1:0] waddr;
	logic [KW-1:0] wdata;
	logic [AW-1:0] raddr;

	logic          p_ok;
	logic          p_up;
	logic          p_put;
	logic [AW-1:0] p_paddr;
	logic [AW-1:0] p_src;
	logic [CW-1:0] p_n;
	logic [CW-1:0] p_cnt;

	logic          eq_k;
	logic          lt_k;
	logic          eq_nk;
	logic          lt_nk;
	logic [CW-1:0] cmp_idx;
	logic          scan_more;

	sut_ram #(
		.W(KW),
		.D(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rd_data)
	);

	assign eq_k      = ($signed(rd_data) == key_q);
	assign lt_k      = ($signed(rd_data) < key_q);
	assign eq_nk     = ($signed(rd_data) == nkey_q);
	assign lt_nk     = ($signed(rd_data) < nkey_q);
	assign cmp_idx   = idx_q - CW'(1);
	assign scan_more = (idx_q != cnt_q);

	assign raddr = cmd.shift ? src_q : idx_q[AW-1:0];
	assign we    = (cmd.shift && pend_q) || (cmd.put && put_q);
	assign waddr = cmd.put ? paddr_q : (up_q ? last_q + AW'(1) : last_q - AW'(1));
	assign wdata = cmd.put ? ((op_q == sut_pkg::OP_INSERT) ? key_q : nkey_q) : rd_data;

	always_comb begin
		p_ok    = 1'b0;
		p_up    = 1'b0;
		p_put   = 1'b0;
		p_paddr = '0;
		p_src   = '0;
		p_n     = '0;
		p_cnt   = cnt_q;
		case (op_q)
			sut_pkg::OP_INSERT: begin
				if (cnt_q < CW'(DEPTH) && !found_k_q) begin
					p_ok    = 1'b1;
					p_up    = 1'b1;
					p_src   = AW'(cnt_q - CW'(1));
					p_n     = cnt_q - ltk_q;
					p_put   = 1'b1;
					p_paddr = AW'(ltk_q);
					p_cnt   = cnt_q + CW'(1);
				end
			end
			sut_pkg::OP_REMOVE: begin
				if (found_k_q) begin
					p_ok  = 1'b1;
					p_src = AW'(pk_q + CW'(1));
					p_n   = cnt_q - CW'(1) - pk_q;
					p_cnt = cnt_q - CW'(1);
				end
			end
			sut_pkg::OP_REPLACE: begin
				if (found_k_q && !found_nk_q) begin
					p_ok  = 1'b1;
					p_put = 1'b1;
					if (ltnk_q > pk_q) begin
						p_src   = AW'(pk_q + CW'(1));
						p_n     = ltnk_q - CW'(1) - pk_q;
						p_paddr = AW'(ltnk_q - CW'(1));
					end else begin
						p_up    = 1'b1;
						p_src   = AW'(pk_q - CW'(1));
						p_n     = pk_q - ltnk_q;
						p_paddr = AW'(ltnk_q);
					end
				end
			end
			default: begin
				p_ok = found_k_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.accept || cmd.plan) begin
				pend_q <= 1'b0;
			end else if (cmd.scan) begin
				pend_q <= scan_more;
			end else if (cmd.shift) begin
				pend_q <= (rem_q != '0);
			end
			if (cmd.plan) begin
				cnt_q <= p_cnt;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q       <= sut_pkg::sut_op_t'(opcode);
			key_q      <= key;
			nkey_q     <= new_key;
			idx_q      <= '0;
			found_k_q  <= 1'b0;
			found_nk_q <= 1'b0;
			pk_q       <= '0;
			ltk_q      <= '0;
			ltnk_q     <= '0;
		end
		if (cmd.scan) begin
			if (scan_more) begin
				idx_q <= idx_q + CW'(1);
			end
			if (pend_q) begin
				if (eq_k) begin
					found_k_q <= 1'b1;
					pk_q      <= cmp_idx;
				end
				if (lt_k) begin
					ltk_q <= ltk_q + CW'(1);
				end
				if (eq_nk) begin
					found_nk_q <= 1'b1;
				end
				if (lt_nk) begin
					ltnk_q <= ltnk_q + CW'(1);
				end
			end
		end
		if (cmd.plan) begin
			okp_q   <= p_ok;
			up_q    <= p_up;
			put_q   <= p_put;
			paddr_q <= p_paddr;
			src_q   <= p_src;
			rem_q   <= p_n;
		end
		if (cmd.shift && rem_q != '0) begin
			src_q  <= up_q ? src_q - AW'(1) : src_q + AW'(1);
			rem_q  <= rem_q - CW'(1);
			last_q <= src_q;
		end
		if (cmd.out_load) begin
			ok_q   <= okp_q;
			pos_q  <= (op_q == sut_pkg::OP_SEARCH && okp_q) ? PW'(pk_q) : '1;
			ocnt_q <= NW'(cnt_q);
		end
	end

	assign sts.scan_done  = !scan_more && !pend_q;
	assign sts.shift_done = (rem_q == '0) && !pend_q;
	assign sts.out_free   = !out_valid_q || !out_stall;

	assign out_valid   = out_valid_q;
	assign ok          = ok_q;
	assign position    = pos_q;
	assign entry_count = ocnt_q;

endmodule

@@ sv/sut_ctrl.sv @@
module sut_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  sut_pkg::sut_sts_t sts,
	output sut_pkg::sut_cmd_t cmd
);

	sut_pkg::sut_state_t state_q;
	sut_pkg::sut_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sut_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			sut_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = sut_pkg::ST_SCAN;
				end
			end
			sut_pkg::ST_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_done) begin
					state_d = sut_pkg::ST_PLAN;
				end
			end
			sut_pkg::ST_PLAN: begin
				cmd.plan = 1'b1;
				state_d  = sut_pkg::ST_SHIFT;
			end
			sut_pkg::ST_SHIFT: begin
				cmd.shift = 1'b1;
				if (sts.shift_done) begin
					state_d = sut_pkg::ST_PUT;
				end
			end
			sut_pkg::ST_PUT: begin
				cmd.put = 1'b1;
				state_d = sut_pkg::ST_DONE;
			end
			sut_pkg::ST_DONE: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = sut_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = sut_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

@@ sv/sorted_unique_table.sv @@
// channel  | handshake          | word
// ---------+--------------------+--------------------------------
// in       | in_valid, in_stall | opcode, key, new_key
// out      | out_valid,out_stall| ok, position, entry_count
//
// one request at a time: a scan of the stored keys over the ram read port, then a plan step,
// a move pass over the words shifted, a put of the new key and a finish that loads the result
// worst case is a remove of the lowest key from a full table
// reset clears the count and control; ram contents need no clearing
// a held result word blocks only the finish of the next request
module sorted_unique_table #(
	parameter int DEPTH = sut_pkg::DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [sut_pkg::OP_W-1:0]          opcode,
	input  logic signed [sut_pkg::KEY_W-1:0]  key,
	input  logic signed [sut_pkg::KEY_W-1:0]  new_key,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              ok,
	output logic signed [sut_pkg::POS_W-1:0]  position,
	output logic [sut_pkg::CNT_W-1:0]         entry_count
);

	sut_pkg::sut_cmd_t cmd;
	sut_pkg::sut_sts_t sts;

	sut_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sts     (sts),
		.cmd     (cmd)
	);

	sut_datapath #(
		.DEPTH(DEPTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.opcode     (opcode),
		.key        (key),
		.new_key    (new_key),
		.out_stall  (out_stall),
		.out_valid  (out_valid),
		.ok         (ok),
		.position   (position),
		.entry_count(entry_count)
	);

	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("accepted a second word while busy");

	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared without a request in flight");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ok || position == '1)
		else $error("failed request carries a position");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && position != '1 |-> ok)
		else $error("position given without success");

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

	localparam int DEPTH      = sut_pkg::DEPTH_DEF;
	localparam int KEY_W      = sut_pkg::KEY_W;
	localparam int POS_W      = sut_pkg::POS_W;
	localparam int CNT_W      = sut_pkg::CNT_W;
	localparam int OP_W       = sut_pkg::OP_W;
	localparam int N_RANDOM   = 1725;
	localparam int QUIET_FROM = 1450;
	localparam int DRAIN_AT   = 600;
	localparam int HOLD_AT    = 900;
	localparam int HOLD_LEN   = 250;
	localparam int IDLE_LIMIT = 3000;
	localparam int POOL_N     = 20;
	localparam int N_ROWS     = 27;
	localparam int GAP_PCT [4] = '{0, 5, 15, 35};

	localparam logic signed [POS_W-1:0] NO_POS  = -5'sd1;
	localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
	localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7fff_ffff;

	typedef struct packed {
		logic                    ok;
		logic signed [POS_W-1:0] position;
		logic [CNT_W-1:0]        entry_count;
	} table_reply_t;

	typedef struct packed {
		sut_pkg::sut_op_t        op;
		logic signed [KEY_W-1:0] k;
		logic signed [KEY_W-1:0] nk;
		logic                    fixed;
		table_reply_t            reply;
	} req_row_t;

	typedef enum int {
		MIX_GROW,
		MIX_SHRINK,
		MIX_EVEN
	} mix_t;

	logic                    clk;
	logic                    arst_n;
	logic                    in_valid;
	logic                    in_stall;
	logic [OP_W-1:0]         opcode;
	logic signed [KEY_W-1:0] key;
	logic signed [KEY_W-1:0] new_key;
	logic                    out_valid;
	logic                    out_stall;
	logic                    ok;
	logic signed [POS_W-1:0] position;
	logic [CNT_W-1:0]        entry_count;

	logic signed [KEY_W-1:0] table_keys [DEPTH];
	int                      table_count;
	table_reply_t            replies_due [$];
	logic signed [KEY_W-1:0] key_pool [POOL_N];
	req_row_t                rows [N_ROWS];
	table_reply_t            head;
	int                      n_sent;
	int                      errors;
	int                      idle_cycles;
	int                      in_gap_pct;
	int                      out_stall_pct;
	bit                      hold_done;

	sorted_unique_table #(
		.DEPTH(DEPTH)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.opcode(opcode),
		.key(key),
		.new_key(new_key),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.ok(ok),
		.position(position),
		.entry_count(entry_count)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// scan stops at the first larger key
	function automatic int find_slot(logic signed [KEY_W-1:0] k);
		for (int i = 0; i < table_count; i++) begin
			if (table_keys[i] == k)
				return i;
			if (k < table_keys[i])
				return -1;
		end
		return -1;
	endfunction

	function automatic bit put_key(logic signed [KEY_W-1:0] k);
		int i;
		if (table_count >= DEPTH || find_slot(k) >= 0)
			return 1'b0;
		i = table_count;
		while (i > 0 && table_keys[i-1] > k) begin
			table_keys[i] = table_keys[i-1];
			i--;
		end
		table_keys[i] = k;
		table_count++;
		return 1'b1;
	endfunction

	function automatic bit drop_key(logic signed [KEY_W-1:0] k);
		int p;
		p = find_slot(k);
		if (p < 0)
			return 1'b0;
		for (int i = p; i + 1 < table_count; i++)
			table_keys[i] = table_keys[i+1];
		table_count--;
		return 1'b1;
	endfunction

	function automatic table_reply_t table_op(sut_pkg::sut_op_t op,
		logic signed [KEY_W-1:0] k, nk);
		table_reply_t r;
		int           p;
		r.ok = 1'b0;
		r.position = NO_POS;
		case (op)
			sut_pkg::OP_INSERT: r.ok = put_key(k);
			sut_pkg::OP_REMOVE: r.ok = drop_key(k);
			sut_pkg::OP_REPLACE: begin
				if (find_slot(k) >= 0 && find_slot(nk) < 0) begin
					void'(drop_key(k));
					void'(put_key(nk));
					r.ok = 1'b1;
				end
			end
			default: begin
				p = find_slot(k);
				if (p >= 0) begin
					r.ok = 1'b1;
					r.position = p[POS_W-1:0];
				end
			end
		endcase
		r.entry_count = table_count[CNT_W-1:0];
		return r;
	endfunction

	// mostly keys already stored or from a small pool, so hits and a full table are common
	function automatic logic signed [KEY_W-1:0] pick_key();
		int r;
		r = $urandom_range(0, 99);
		if (r < 30 && table_count > 0)
			return table_keys[$urandom_range(0, table_count - 1)];
		if (r < 85)
			return key_pool[$urandom_range(0, POOL_N - 1)];
		return $urandom;
	endfunction

	function automatic sut_pkg::sut_op_t pick_op(mix_t m);
		int r;
		int ins_pct;
		int rem_pct;
		case (m)
			MIX_GROW: begin
				ins_pct = 55;
				rem_pct = 10;
			end
			MIX_SHRINK: begin
				ins_pct = 15;
				rem_pct = 50;
			end
			default: begin
				ins_pct = 30;
				rem_pct = 25;
			end
		endcase
		r = $urandom_range(0, 99);
		if (r < ins_pct)
			return sut_pkg::OP_INSERT;
		if (r < ins_pct + rem_pct)
			return sut_pkg::OP_REMOVE;
		if (r < ins_pct + rem_pct + 20)
			return sut_pkg::OP_REPLACE;
		return sut_pkg::OP_SEARCH;
	endfunction

	task automatic send_word(sut_pkg::sut_op_t op, logic signed [KEY_W-1:0] k, nk);
		in_valid <= 1'b1;
		opcode <= op;
		key <= k;
		new_key <= nk;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		n_sent++;
	endtask

	task automatic maybe_gap();
		if (in_gap_pct > 0 && $urandom_range(1, 100) <= in_gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	endtask

	initial begin
		mix_t                    mix;
		sut_pkg::sut_op_t        op;
		logic signed [KEY_W-1:0] k;
		logic signed [KEY_W-1:0] nk;
		table_reply_t            pred;
		in_valid <= 1'b0;
		opcode <= sut_pkg::OP_INSERT;
		key <= '0;
		new_key <= '0;
		arst_n <= 1'b0;
		table_count = 0;
		n_sent = 0;
		errors = 0;
		in_gap_pct = 15;
		out_stall_pct = 15;
		hold_done = 1'b0;
		mix = MIX_EVEN;

		key_pool[0] = KEY_MIN;
		key_pool[1] = KEY_MAX;
		key_pool[2] = 0;
		key_pool[3] = -1;
		key_pool[4] = 1;
		key_pool[5] = KEY_MIN + 1;
		key_pool[6] = KEY_MAX - 1;
		for (int i = 7; i < POOL_N; i++)
			key_pool[i] = (i % 2) ? $urandom : $urandom_range(0, 40) - 20;

		rows = '{
			'{sut_pkg::OP_SEARCH,  32'sd0,  32'sd0,  1'b1, '{1'b0, NO_POS,  5'd0}},
			'{sut_pkg::OP_REMOVE,  32'sd5,  32'sd0,  1'b1, '{1'b0, NO_POS,  5'd0}},
			'{sut_pkg::OP_INSERT,  KEY_MAX, 32'sd0,  1'b1, '{1'b1, NO_POS,  5'd1}},
			'{sut_pkg::OP_INSERT,  KEY_MIN, KEY_MAX, 1'b1, '{1'b1, NO_POS,  5'd2}},
			'{sut_pkg::OP_SEARCH,  KEY_MIN, 32'sd0,  1'b1, '{1'b1, 5'sd0,   5'd2}},
			'{sut_pkg::OP_INSERT,  KEY_MAX, 32'sd0,  1'b1, '{1'b0, NO_POS,  5'd2}},
			'{sut_pkg::OP_INSERT,  32'sd0,  KEY_MIN, 1'b0, '0},
			'{sut_pkg::OP_REPLACE, 32'sd0,  32'sd0,  1'b1, '{1'b0, NO_POS,  5'd3}},
			'{sut_pkg::OP_REPLACE, KEY_MAX, KEY_MIN, 1'b1, '{1'b0, NO_POS,  5'd3}},
			'{sut_pkg::OP_REPLACE, 32'sd0,  -32'sd5, 1'b0, '0},
			'{sut_pkg::OP_REMOVE,  32'sd7,  32'sd0,  1'b1, '{1'b0, NO_POS,  5'd3}},
			'{sut_pkg::OP_INSERT,  32'sd1,  32'sd0,  1'b1, '{1'b1, NO_POS,  5'd4}},
			'{sut_pkg::OP_INSERT,  32'sd2,  32'sd0,  1'b1, '{1'b1, NO_POS,  5'd5}},
			'{sut_pkg::OP_INSERT,  32'sd3,  32'sd0,  1'b1, '{1'b1, NO_POS,  5'd6}},
			'{sut_pkg::OP_INSERT,  32'sd4,  32'sd0,  1'b1, '{1'b1, NO_POS,  5'd7}},
			'{sut_pkg::OP_INSERT,  32'sd5,  32'sd0,  1'b1, '{1'b1, NO_POS,  5'd8}},
			'{sut_pkg::OP_INSERT,  32'sd6,  32'sd0,  1'b1, '{1'b1, NO_POS,  5'd9}},
			'{sut_pkg::OP_INSERT,  32'sd7,  32'sd0,  1'b1, '{1'b1, NO_POS,  5'd10}},
			'{sut_pkg::OP_INSERT,  32'sd8,  32'sd0,  1'b1, '{1'b1, NO_POS,  5'd11}},
			'{sut_pkg::OP_INSERT,  32'sd9,  32'sd0,  1'b1, '{1'b1, NO_POS,  5'd12}},
			'{sut_pkg::OP_INSERT,  32'sd10, 32'sd0,  1'b1, '{1'b1, NO_POS,  5'd13}},
			'{sut_pkg::OP_INSERT,  32'sd11, 32'sd0,  1'b1, '{1'b1, NO_POS,  5'd14}},
			'{sut_pkg::OP_INSERT,  32'sd12, 32'sd0,  1'b1, '{1'b1, NO_POS,  5'd15}},
			'{sut_pkg::OP_INSERT,  32'sd13, 32'sd0,  1'b1, '{1'b1, NO_POS,  5'd16}},
			'{sut_pkg::OP_INSERT,  32'sd100, 32'sd0, 1'b1, '{1'b0, NO_POS,  5'd16}},
			'{sut_pkg::OP_SEARCH,  KEY_MAX, 32'sd0,  1'b1, '{1'b1, 5'sd15,  5'd16}},
			'{sut_pkg::OP_REMOVE,  KEY_MIN, 32'sd0,  1'b1, '{1'b1, NO_POS,  5'd15}}
		};

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) begin
			send_word(rows[i].op, rows[i].k, rows[i].nk);
			pred = table_op(rows[i].op, rows[i].k, rows[i].nk);
			replies_due.push_back(rows[i].fixed ? rows[i].reply : pred);
			maybe_gap();
		end
		in_valid <= 1'b0;
		do @(posedge clk); while (replies_due.size() != 0);

		for (int i = 0; i < N_RANDOM; i++) begin
			if (i % 120 == 0) begin
				mix = mix_t'($urandom_range(0, 2));
				in_gap_pct = GAP_PCT[$urandom_range(0, 3)];
				out_stall_pct = GAP_PCT[$urandom_range(0, 3)];
			end
			if (i >= QUIET_FROM) begin
				in_gap_pct = 0;
				out_stall_pct = 0;
			end
			// sender waits for the table to go quiet
			if (i == DRAIN_AT) begin
				in_valid <= 1'b0;
				do @(posedge clk); while (replies_due.size() != 0);
			end
			op = pick_op(mix);
			k = pick_key();
			nk = (op == sut_pkg::OP_REPLACE) ? pick_key() : $urandom;
			send_word(op, k, nk);
			replies_due.push_back(table_op(op, k, nk));
			maybe_gap();
		end
		in_valid <= 1'b0;

		do @(posedge clk); while (replies_due.size() != 0);
		repeat (2 * DEPTH + 20) @(posedge clk);
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// result side: one long hold-off, otherwise short random bursts
	initial begin
		out_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!hold_done && n_sent >= HOLD_AT) begin
				hold_done = 1'b1;
				out_stall <= 1'b1;
				repeat (HOLD_LEN) @(posedge clk);
				out_stall <= 1'b0;
			end else if (out_stall_pct > 0 && $urandom_range(1, 100) <= out_stall_pct) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 8)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (replies_due.size() == 0) begin
				$display("%0t: result word with none pending: ok=%0b position=%0d entry_count=%0d",
					$time, ok, position, entry_count);
				errors++;
			end else begin
				head = replies_due.pop_front();
				if (ok !== head.ok) begin
					$display("%0t: ok expected %0b actual %0b", $time, head.ok, ok);
					errors++;
				end
				if (position !== head.position) begin
					$display("%0t: position expected %0d actual %0d", $time, head.position,
						position);
					errors++;
				end
				if (entry_count !== head.entry_count) begin
					$display("%0t: entry_count expected %0d actual %0d", $time,
						head.entry_count, entry_count);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

endmodule
